// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define DVI_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// implication in the next cycle
`define DVI_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/dvi_pkg.sv =====
// types and constants of the damped velocity integrator
package dvi_pkg;

    localparam int FIELD_BITS    = 32;
    localparam int FRICTION_BITS = 31;

    // floor(x / 10) = (x * RECIP10) >> RECIP10_SHIFT for any 32-bit x
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_LOAD = 2'd1;
    localparam logic [1:0] MODE_CLR  = 2'd2;
    localparam logic [1:0] MODE_NOP  = 2'd3;

    typedef struct packed {
        logic [1:0]                   mode;
        logic signed [FIELD_BITS-1:0] new_acc_x;
        logic signed [FIELD_BITS-1:0] new_acc_y;
        logic signed [FIELD_BITS-1:0] new_acc_z;
    } dvi_in_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] out_pos_x;
        logic signed [FIELD_BITS-1:0] out_pos_y;
        logic signed [FIELD_BITS-1:0] out_pos_z;
        logic signed [FIELD_BITS-1:0] out_vel_x;
        logic signed [FIELD_BITS-1:0] out_vel_y;
        logic signed [FIELD_BITS-1:0] out_vel_z;
        logic signed [FIELD_BITS-1:0] out_acc_x;
        logic signed [FIELD_BITS-1:0] out_acc_y;
        logic signed [FIELD_BITS-1:0] out_acc_z;
    } dvi_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_VCHK,
        S_SQ_GO,
        S_SQ_WAIT,
        S_CMP,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_POS,
        S_DONE
    } dvi_state_t;

endpackage

// ===== rtl/core/dvi_sqsum.sv =====
// bit-serial sum of squares of three magnitudes
module dvi_sqsum
    import dvi_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [WORD_BITS-1:0]     mag_x,
    input  logic [WORD_BITS-1:0]     mag_y,
    input  logic [WORD_BITS-1:0]     mag_z,
    output logic                     done,
    output logic [2*WORD_BITS-1:0]   sum
);
    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [1:0]       axis_reg, axis_next;
    logic [2*W-1:0]   mcand_reg, mcand_next;
    logic [W-1:0]     mplr_reg, mplr_next;
    logic [2*W-1:0]   sum_reg, sum_next;
    logic [W-1:0]     next_mag;

    always_comb
    begin
        next_mag = (axis_reg == 2'd0) ? mag_y : mag_z;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        sum_next   = sum_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CW'(W - 1);
            axis_next  = 2'd0;
            mcand_next = (2*W)'(mag_x);
            mplr_next  = mag_x;
            sum_next   = '0;
        end
        else if (busy_reg)
        begin
            // one multiplier bit per cycle
            if (mplr_reg[0])
            begin
                sum_next = sum_reg + mcand_reg;
            end
            mcand_next = mcand_reg << 1;
            mplr_next  = mplr_reg >> 1;
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                if (axis_reg == 2'd2)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    cnt_next   = CW'(W - 1);
                    mcand_next = (2*W)'(next_mag);
                    mplr_next  = next_mag;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            axis_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            axis_reg <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
        sum_reg   <= sum_next;
    end

    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

// ===== rtl/core/dvi_sqrt.sv =====
// restoring integer square root, one result bit per cycle
module dvi_sqrt
    import dvi_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [2*WORD_BITS-1:0] radicand,
    output logic                   done,
    output logic [WORD_BITS-1:0]   root
);
    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W);
    localparam int RB = W + 3;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [2*W-1:0]   nsh_reg, nsh_next;
    logic [RB-1:0]    rem_reg, rem_next;
    logic [W-1:0]     root_reg, root_next;
    logic [RB-1:0]    rem_sh;
    logic [RB-1:0]    trial;

    always_comb
    begin
        rem_sh    = {rem_reg[RB-3:0], nsh_reg[2*W-1 -: 2]};
        trial     = RB'({root_reg, 2'b01});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        nsh_next  = nsh_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            nsh_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            nsh_next = nsh_reg << 2;
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nsh_reg  <= nsh_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/core/dvi_div.sv =====
// restoring unsigned divider, one numerator bit per cycle
module dvi_div
    import dvi_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int NUM_BITS  = 51
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NUM_BITS-1:0]   numer,
    input  logic [WORD_BITS-1:0]  denom,
    output logic                  done,
    output logic [WORD_BITS-1:0]  quot
);
    localparam int W  = WORD_BITS;
    localparam int NB = NUM_BITS;
    localparam int CW = $clog2(NB);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [NB-1:0]   num_reg, num_next;
    logic [W-1:0]    den_reg, den_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic [W-1:0]    quo_reg, quo_next;
    logic [W:0]      rem_sh;
    logic [W:0]      diff;

    always_comb
    begin
        rem_sh    = {rem_reg, num_reg[NB-1]};
        diff      = rem_sh - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NB - 1);
            num_next  = numer;
            den_next  = denom;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            // quotient never exceeds the word, so upper bits fall away
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== rtl/core/damped_velocity_integrator_top.sv =====
// top level of the damped velocity integrator: sequencer, state and output register
//
// keeps a 3-axis acceleration, velocity and position as signed fixed point words
// (WORD_BITS wide, FRAC_BITS fraction bits) and returns the whole state, clipped
// to 32 bits, for every input beat. a load, clear or no-op beat goes from idle
// straight to the done state. a tick runs the acceleration pass, axis by axis,
// when the acceleration is nonzero; whenever the velocity is nonzero it runs the
// bit-serial sum of squares and the position pass, and when the speed exceeds 5 it
// also runs the speed clamp first: a square root and three divides. those serial
// units set the rate; only one beat is in the block at a time, but a new beat is
// taken while the previous result still waits in the output register
module damped_velocity_integrator_top
    import dvi_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  dvi_in_t                   in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output dvi_out_t                  out_data,
    input  logic                      cfg_wr_en,
    input  logic [FRICTION_BITS-1:0]  cfg_wr_data
);
`include "assert_macros.svh"

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int XW = (W > FIELD_BITS) ? W : FIELD_BITS;
    localparam int DW = (W > FRICTION_BITS) ? W : FRICTION_BITS;
    localparam int NB = W + F + 3;
    localparam int SW = (2*W > 2*F + 5) ? 2*W : 2*F + 5;

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [FIELD_BITS-1:0] FMAX = {1'b0, {(FIELD_BITS-1){1'b1}}};
    localparam logic signed [FIELD_BITS-1:0] FMIN = {1'b1, {(FIELD_BITS-1){1'b0}}};
    // square of the speed limit 5 << FRAC_BITS
    localparam logic [SW-1:0] LIM2 = SW'(25) << (2*F);

    // magnitude of a word, fits unsigned in the same width
    function automatic logic [W-1:0] mag_of(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = (W+1)'(a) + (W+1)'(b);
        if (s > (W+1)'(WMAX))
            return WMAX;
        else if (s < (W+1)'(WMIN))
            return WMIN;
        else
            return W'(s);
    endfunction

    // move toward zero by f, clear when the magnitude is below f
    function automatic logic signed [W-1:0] decay(input logic signed [W-1:0] v,
                                                 input logic [FRICTION_BITS-1:0] f);
        logic [DW-1:0] m;
        logic [DW-1:0] fx;
        logic [W-1:0]  r;
        m  = DW'(mag_of(v));
        fx = DW'(f);
        r  = W'(m - fx);
        if (f == '0)
            return v;
        else if (m < fx)
            return '0;
        else
            return v[W-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [W-1:0] sat_in(input logic signed [FIELD_BITS-1:0] v);
        logic signed [XW-1:0] x;
        x = XW'(v);
        if (x > XW'(WMAX))
            return WMAX;
        else if (x < XW'(WMIN))
            return WMIN;
        else
            return W'(x);
    endfunction

    function automatic logic signed [FIELD_BITS-1:0] sat_out(input logic signed [W-1:0] v);
        logic signed [XW-1:0] x;
        x = XW'(v);
        if (x > XW'(FMAX))
            return FMAX;
        else if (x < XW'(FMIN))
            return FMIN;
        else
            return FIELD_BITS'(x);
    endfunction

    // state
    dvi_state_t state_reg, state_next;
    logic [1:0] axis_reg;

    logic signed [W-1:0] acc_reg [3];
    logic signed [W-1:0] vel_reg [3];
    logic signed [W-1:0] pos_reg [3];

    logic [FRICTION_BITS-1:0] friction_reg;
    logic [FRICTION_BITS-1:0] f10_reg;
    logic [FRICTION_BITS+31:0] f10_prod;

    logic [W-1:0] len_reg;

    dvi_out_t out_reg;
    logic     out_valid_reg, out_valid_next;

    // control
    logic accept;
    logic out_load;
    logic sq_start, sqrt_start, div_start;
    logic sq_done, sqrt_done, div_done;
    logic [2*W-1:0] sq_sum;
    logic [W-1:0]   sqrt_root;
    logic [W-1:0]   div_quot;
    logic [W-1:0]   axis_mag;
    logic [NB-1:0]  div_numer;
    logic           acc_nz, vel_nz, over_limit;

    assign accept     = in_valid & in_ready;
    assign acc_nz     = (acc_reg[0] != '0) | (acc_reg[1] != '0) | (acc_reg[2] != '0);
    assign vel_nz     = (vel_reg[0] != '0) | (vel_reg[1] != '0) | (vel_reg[2] != '0);
    assign over_limit = SW'(sq_sum) > LIM2;
    assign axis_mag   = mag_of(vel_reg[axis_reg]);
    // |v| * (5 << FRAC_BITS) as two shifted copies
    assign div_numer  = (NB'(axis_mag) << (F + 2)) + (NB'(axis_mag) << F);

    // friction / 10 by reciprocal multiply, registered
    assign f10_prod = (FRICTION_BITS+32)'(friction_reg) * (FRICTION_BITS+32)'(RECIP10);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.mode == MODE_TICK)
                        state_next = acc_nz ? S_ACC : S_VCHK;
                    else
                        state_next = S_DONE;
                end
            end
            S_ACC:
            begin
                if (axis_reg == 2'd2)
                    state_next = S_VCHK;
            end
            S_VCHK:      state_next = vel_nz ? S_SQ_GO : S_DONE;
            S_SQ_GO:     state_next = S_SQ_WAIT;
            S_SQ_WAIT:
            begin
                if (sq_done)
                    state_next = S_CMP;
            end
            S_CMP:       state_next = over_limit ? S_SQRT_GO : S_POS;
            S_SQRT_GO:   state_next = S_SQRT_WAIT;
            S_SQRT_WAIT:
            begin
                if (sqrt_done)
                    state_next = S_DIV_GO;
            end
            S_DIV_GO:    state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (div_done)
                    state_next = (axis_reg == 2'd2) ? S_POS : S_DIV_GO;
            end
            S_POS:
            begin
                if (axis_reg == 2'd2)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        sq_start   = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:    in_ready   = 1'b1;
            S_SQ_GO:   sq_start   = 1'b1;
            S_SQRT_GO: sqrt_start = 1'b1;
            S_DIV_GO:  div_start  = 1'b1;
            // the result register frees up once the old beat leaves
            S_DONE:    out_load   = ~out_valid_reg | out_ready;
            default:   in_ready   = 1'b0;
        endcase
    end

    assign out_valid_next = out_load | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            friction_reg  <= '0;
            f10_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= '0;
                vel_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            f10_reg       <= FRICTION_BITS'(f10_prod >> RECIP10_SHIFT);
            if (cfg_wr_en)
                friction_reg <= cfg_wr_data;

            // load and clear beats
            if (accept)
            begin
                case (in_data.mode)
                    MODE_LOAD:
                    begin
                        acc_reg[0] <= sat_in(in_data.new_acc_x);
                        acc_reg[1] <= sat_in(in_data.new_acc_y);
                        acc_reg[2] <= sat_in(in_data.new_acc_z);
                    end
                    MODE_CLR:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            acc_reg[i] <= '0;
                            vel_reg[i] <= '0;
                            pos_reg[i] <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // one axis per cycle through the adders
            if (state_reg == S_ACC)
            begin
                vel_reg[axis_reg] <= sat_add(vel_reg[axis_reg], acc_reg[axis_reg]);
                acc_reg[axis_reg] <= decay(acc_reg[axis_reg], friction_reg);
                axis_reg          <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 1'b1;
            end

            // clamped axis keeps its sign
            if (state_reg == S_DIV_WAIT && div_done)
            begin
                vel_reg[axis_reg] <= vel_reg[axis_reg][W-1] ? -$signed(div_quot)
                                                            : $signed(div_quot);
                axis_reg          <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 1'b1;
            end

            if (state_reg == S_POS)
            begin
                pos_reg[axis_reg] <= sat_add(pos_reg[axis_reg], vel_reg[axis_reg]);
                vel_reg[axis_reg] <= decay(vel_reg[axis_reg], f10_reg);
                axis_reg          <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SQRT_WAIT && sqrt_done)
            len_reg <= sqrt_root;
        if (out_load)
        begin
            out_reg.out_pos_x <= sat_out(pos_reg[0]);
            out_reg.out_pos_y <= sat_out(pos_reg[1]);
            out_reg.out_pos_z <= sat_out(pos_reg[2]);
            out_reg.out_vel_x <= sat_out(vel_reg[0]);
            out_reg.out_vel_y <= sat_out(vel_reg[1]);
            out_reg.out_vel_z <= sat_out(vel_reg[2]);
            out_reg.out_acc_x <= sat_out(acc_reg[0]);
            out_reg.out_acc_y <= sat_out(acc_reg[1]);
            out_reg.out_acc_z <= sat_out(acc_reg[2]);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // speed clamp units
    dvi_sqsum #(
        .WORD_BITS (W)
    ) u_sqsum (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .mag_x (mag_of(vel_reg[0])),
        .mag_y (mag_of(vel_reg[1])),
        .mag_z (mag_of(vel_reg[2])),
        .done  (sq_done),
        .sum   (sq_sum)
    );

    dvi_sqrt #(
        .WORD_BITS (W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_sum),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    dvi_div #(
        .WORD_BITS (W),
        .NUM_BITS  (NB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (len_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // a waiting result is never overwritten
    `DVI_ASSERT_NEXT(a_hold_done, clk, rst_n,
        (state_reg == S_DONE && out_valid_reg && !out_ready), (state_reg == S_DONE),
        "result register overwritten while full")
    // divider only finishes while the sequencer waits for it
    `DVI_ASSERT_NOW(a_div_done, clk, rst_n,
        div_done, (state_reg == S_DIV_WAIT), "divider finished out of sequence")
    // clear beat empties the state, checked on one axis each of position, velocity and acceleration
    `DVI_ASSERT_NEXT(a_clear, clk, rst_n,
        (accept && in_data.mode == MODE_CLR),
        (pos_reg[0] == '0 && vel_reg[1] == '0 && acc_reg[2] == '0),
        "clear beat left state behind")

endmodule
